>>> design/fspm_pkg.sv
// ----------------------------------------------------------------------------
// fspm_pkg
// Shared types and codes of the flash sector page mapper: request codes,
// result status codes and the layout of one sector table entry.
// ----------------------------------------------------------------------------
package fspm_pkg;

  // request codes
  localparam logic [2:0] REQ_CLEAR  = 3'd0;
  localparam logic [2:0] REQ_APPEND = 3'd1;
  localparam logic [2:0] REQ_P2A    = 3'd2;
  localparam logic [2:0] REQ_A2P    = 3'd3;
  localparam logic [2:0] REQ_RANGE  = 3'd4;
  localparam logic [2:0] REQ_COUNT  = 3'd5;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISS    = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  // one sector of the layout table
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] page_bytes;
    logic [15:0] page_total;
  } entry_t;

endpackage

>>> design/fspm_table.sv
// ----------------------------------------------------------------------------
// fspm_table
// Sector table memory: one write port, one read port with registered data.
// Entries hold whatever was last written; unwritten entries are never read.
// ----------------------------------------------------------------------------
module fspm_table #(
  parameter int MaxSectors = 16,
  parameter int AW = 4
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  fspm_pkg::entry_t     wr_data_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output fspm_pkg::entry_t     rd_data_o
);

  fspm_pkg::entry_t mem [MaxSectors];
  fspm_pkg::entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/fspm_divider.sv
// ----------------------------------------------------------------------------
// fspm_divider
// Restoring radix-2 divider, 32 by 32 bits, one quotient bit per cycle.
// Quotient is valid in the cycle done_o is high.
// ----------------------------------------------------------------------------
module fspm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quotient_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] divisor_q;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // one trial subtraction per cycle
  always_comb begin
    trial  = {rem_q, quo_q[31]};
    diff   = trial - {1'b0, divisor_q};
    fits   = !diff[32];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[31:0] : trial[31:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      divisor_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/flash_sector_page_mapper_top.sv
// ----------------------------------------------------------------------------
// flash_sector_page_mapper_top
// Sector layout table of one flash region with page and address lookups.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start_i high and busy_o low; busy_o
// is high until done_o, so one request is in flight at a time. Exactly one
// result follows, shown for one cycle with done_o high; the receiver takes it
// at that cycle's closing edge and cannot stall it. region_base is written
// over the APB port (byte address 0); the user must do so only while idle,
// which the block does not enforce. Clear, refused append and unknown
// request codes are answered from idle (busy_o stays low). Append goes
// through the multiply and finish states, range check through the range
// state. Count pages, page to address and address to page walk the loaded
// sectors in order, one table read per sector; address to page ends a hit
// in the 32-step bit-serial divider.
// Reset empties the table (sector count and region size to zero) and sets
// region_base to zero; table memory contents are left as they are.
// ----------------------------------------------------------------------------
module flash_sector_page_mapper_top #(
  parameter int MAX_SECTORS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] query_address_i,
  input  logic [31:0] range_length_i,
  input  logic [31:0] query_page_i,
  input  logic [15:0] new_sector_pages_i,
  input  logic [31:0] new_sector_page_bytes_i,
  // result channel
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] page_address_o,
  output logic [31:0] page_bytes_o,
  output logic [19:0] page_number_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_SECTORS + 1);
  localparam int AW = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_APP_MUL = 4'd1;
  localparam logic [3:0] S_APP_FIN = 4'd2;
  localparam logic [3:0] S_RANGE   = 4'd3;
  localparam logic [3:0] S_RD      = 4'd4;
  localparam logic [3:0] S_EVAL    = 4'd5;
  localparam logic [3:0] S_SPAN    = 4'd6;
  localparam logic [3:0] S_ADDR    = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [31:0]   region_base_q;
  logic [CW-1:0] used_q, used_d;
  logic [31:0]   region_size_q, region_size_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [19:0]   acc_q, acc_d;

  // request payload
  logic [2:0]    req_q;
  logic [31:0]   addr_q;
  logic [31:0]   len_q;
  logic [31:0]   walk_q, walk_d;
  logic [15:0]   npages_q;
  logic [31:0]   nbytes_q;
  logic          accept;

  // result register
  logic          done_q, done_d;
  logic [1:0]    status_q, status_d;
  logic [31:0]   paddr_q, paddr_d;
  logic [31:0]   pbytes_q, pbytes_d;
  logic [19:0]   pnum_q, pnum_d;

  // shared multiplier
  logic          mul_en;
  logic [15:0]   mul_a;
  logic [31:0]   mul_b;
  logic [47:0]   prod_q;
  logic [31:0]   off_q;
  logic          ge_q;

  // table and divider
  logic              tbl_we;
  fspm_pkg::entry_t  tbl_wdata;
  logic              tbl_re;
  fspm_pkg::entry_t  rd;
  logic              div_start;
  logic              div_done;
  logic [31:0]       div_quo;

  // range check terms
  logic [31:0]   rng_off;
  logic [31:0]   rng_left;
  logic          rng_ok;

  logic          app_refused;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign app_refused = (used_q == CW'(MAX_SECTORS)) || (new_sector_pages_i == '0) ||
                       (new_sector_page_bytes_i == '0);

  // APB: a single register, low address bits ignored
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : region_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q <= '0;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      region_base_q <= pwdata;
    end
  end

  fspm_table #(
    .MaxSectors (MAX_SECTORS),
    .AW         (AW)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_we),
    .wr_addr_i (used_q[AW-1:0]),
    .wr_data_i (tbl_wdata),
    .rd_en_i   (tbl_re),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd)
  );

  fspm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (off_q),
    .divisor_i  (rd.page_bytes),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // new entry, written at the append transfer
  assign tbl_wdata = '{start:      region_base_q + region_size_q,
                       page_bytes: new_sector_page_bytes_i,
                       page_total: new_sector_pages_i};
  assign tbl_we = accept && (req_type_i == fspm_pkg::REQ_APPEND) && !app_refused;
  assign tbl_re = (state_q == S_RD) && (idx_q != used_q);

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = npages_q;
    mul_b  = nbytes_q;
    if (state_q == S_APP_MUL) begin
      mul_en = 1'b1;
    end else if (state_q == S_EVAL) begin
      mul_en = (req_q == fspm_pkg::REQ_P2A) || (req_q == fspm_pkg::REQ_A2P);
      mul_a  = (req_q == fspm_pkg::REQ_P2A) ? walk_q[15:0] : rd.page_total;
      mul_b  = rd.page_bytes;
    end
  end

  // range check on the latched request
  assign rng_off  = addr_q - region_base_q;
  assign rng_left = region_size_q - rng_off;
  assign rng_ok   = (len_q == '0) ||
                    ((addr_q >= region_base_q) && (rng_off <= region_size_q) &&
                     (len_q <= rng_left));

  // sequencer
  always_comb begin
    state_d       = state_q;
    used_d        = used_q;
    region_size_d = region_size_q;
    idx_d         = idx_q;
    acc_d         = acc_q;
    walk_d        = walk_q;
    div_start     = 1'b0;
    done_d        = 1'b0;
    status_d      = status_q;
    paddr_d       = paddr_q;
    pbytes_d      = pbytes_q;
    pnum_d        = pnum_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          idx_d    = '0;
          acc_d    = '0;
          walk_d   = query_page_i;
          status_d = fspm_pkg::STATUS_MISS;
          paddr_d  = '0;
          pbytes_d = '0;
          pnum_d   = '0;
          unique case (req_type_i)
            fspm_pkg::REQ_CLEAR: begin
              used_d        = '0;
              region_size_d = '0;
              status_d      = fspm_pkg::STATUS_OK;
              done_d        = 1'b1;
            end
            fspm_pkg::REQ_APPEND: begin
              if (app_refused) begin
                status_d = fspm_pkg::STATUS_REFUSED;
                done_d   = 1'b1;
              end else begin
                state_d = S_APP_MUL;
              end
            end
            fspm_pkg::REQ_P2A,
            fspm_pkg::REQ_A2P,
            fspm_pkg::REQ_COUNT: begin
              state_d = S_RD;
            end
            fspm_pkg::REQ_RANGE: begin
              state_d = S_RANGE;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_APP_MUL: begin
        state_d = S_APP_FIN;
      end

      // region grows by pages * page size, modulo 2^32
      S_APP_FIN: begin
        region_size_d = region_size_q + prod_q[31:0];
        used_d        = used_q + CW'(1);
        status_d      = fspm_pkg::STATUS_OK;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end

      S_RANGE: begin
        status_d = rng_ok ? fspm_pkg::STATUS_OK : fspm_pkg::STATUS_MISS;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      // issue a table read, or end the walk
      S_RD: begin
        if (idx_q == used_q) begin
          if (req_q == fspm_pkg::REQ_COUNT) begin
            status_d = fspm_pkg::STATUS_OK;
            pnum_d   = acc_q;
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_EVAL;
        end
      end

      // entry data valid here
      S_EVAL: begin
        if (req_q == fspm_pkg::REQ_COUNT) begin
          acc_d   = acc_q + {4'd0, rd.page_total};
          idx_d   = idx_q + CW'(1);
          state_d = S_RD;
        end else if (req_q == fspm_pkg::REQ_P2A) begin
          if (walk_q < {16'd0, rd.page_total}) begin
            state_d = S_ADDR;
          end else begin
            walk_d  = walk_q - {16'd0, rd.page_total};
            idx_d   = idx_q + CW'(1);
            state_d = S_RD;
          end
        end else begin
          state_d = S_SPAN;
        end
      end

      // address inside this sector's span?
      S_SPAN: begin
        if (ge_q && ({16'd0, off_q} < prod_q)) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          acc_d   = acc_q + {4'd0, rd.page_total};
          idx_d   = idx_q + CW'(1);
          state_d = S_RD;
        end
      end

      S_ADDR: begin
        status_d = fspm_pkg::STATUS_OK;
        paddr_d  = rd.start + prod_q[31:0];
        pbytes_d = rd.page_bytes;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      S_DIV: begin
        if (div_done) begin
          status_d = fspm_pkg::STATUS_OK;
          pnum_d   = acc_q + div_quo[19:0];
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      used_q        <= '0;
      region_size_q <= '0;
      done_q        <= 1'b0;
      idx_q         <= '0;
    end else begin
      state_q       <= state_d;
      used_q        <= used_d;
      region_size_q <= region_size_d;
      done_q        <= done_d;
      idx_q         <= idx_d;
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    walk_q   <= walk_d;
    status_q <= status_d;
    paddr_q  <= paddr_d;
    pbytes_q <= pbytes_d;
    pnum_q   <= pnum_d;
    if (accept) begin
      req_q    <= req_type_i;
      addr_q   <= query_address_i;
      len_q    <= range_length_i;
      npages_q <= new_sector_pages_i;
      nbytes_q <= new_sector_page_bytes_i;
    end
    if (mul_en) begin
      prod_q <= {32'd0, mul_a} * {16'd0, mul_b};
    end
    if (state_q == S_EVAL) begin
      off_q <= addr_q - rd.start;
      ge_q  <= (addr_q >= rd.start);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign page_address_o = paddr_q;
  assign page_bytes_o   = pbytes_q;
  assign page_number_o  = pnum_q;

endmodule

>>> tb/flash_sector_page_mapper_top_tb.sv
// ----------------------------------------------------------------------------
// flash_sector_page_mapper_top_tb
// Self-checking bench for the flash sector page mapper. Requests go in over
// the start/busy port. A cycle-free model of the sector table predicts one
// result per request, and each done_o pulse is checked against the oldest
// prediction. A directed pass comes first, then random layouts under several
// region bases and sender idle rates.
// ----------------------------------------------------------------------------
module flash_sector_page_mapper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH      = 16;
  localparam int          CYCLE_LIMIT      = 600000;
  localparam int          MAX_PRINTS       = 40;
  localparam logic [2:0]  REQ_RSVD6        = 3'd6;
  localparam logic [2:0]  REQ_RSVD7        = 3'd7;
  localparam logic [2:0]  ADDR_REGION_BASE = 3'd0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [31:0] length;
    logic [31:0] page;
    logic [15:0] sector_pages;
    logic [31:0] sector_page_bytes;
  } map_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page_address;
    logic [31:0] page_bytes;
    logic [19:0] page_number;
  } lookup_result_t;

  // DUT signals
  logic        clk_i                   = 1'b0;
  logic        rst_ni                  = 1'b0;
  logic        start_i                 = 1'b0;
  logic        busy_o;
  logic [2:0]  req_type_i              = '0;
  logic [31:0] query_address_i         = '0;
  logic [31:0] range_length_i          = '0;
  logic [31:0] query_page_i            = '0;
  logic [15:0] new_sector_pages_i      = '0;
  logic [31:0] new_sector_page_bytes_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] page_address_o;
  logic [31:0] page_bytes_o;
  logic [19:0] page_number_o;
  logic        psel                    = 1'b0;
  logic        penable                 = 1'b0;
  logic        pwrite                  = 1'b0;
  logic [2:0]  paddr                   = '0;
  logic [31:0] pwdata                  = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the sector table and region register
  fspm_pkg::entry_t layout_tbl [TABLE_DEPTH];
  int          sectors_loaded = 0;
  logic [31:0] region_bytes   = '0;
  logic [31:0] model_base     = '0;

  lookup_result_t pending_results[$];
  lookup_result_t result_want;
  int          err_count      = 0;
  int          accepted_items = 0;
  int          gap_percent    = 0;
  int          cycle_count    = 0;

  flash_sector_page_mapper_top u_top (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .start_i                 (start_i),
    .busy_o                  (busy_o),
    .req_type_i              (req_type_i),
    .query_address_i         (query_address_i),
    .range_length_i          (range_length_i),
    .query_page_i            (query_page_i),
    .new_sector_pages_i      (new_sector_pages_i),
    .new_sector_page_bytes_i (new_sector_page_bytes_i),
    .done_o                  (done_o),
    .status_o                (status_o),
    .page_address_o          (page_address_o),
    .page_bytes_o            (page_bytes_o),
    .page_number_o           (page_number_o),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < MAX_PRINTS) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  function automatic logic [31:0] loaded_page_total();
    logic [31:0] total;
    total = '0;
    for (int i = 0; i < sectors_loaded; i++) begin
      total = total + {16'b0, layout_tbl[i].page_total};
    end
    return total;
  endfunction

  // expected result of one request; updates the shadow table
  function automatic lookup_result_t predict_mapper(input map_request_t rq);
    lookup_result_t res;
    logic [31:0]    walk_idx;
    logic [31:0]    page_base;
    logic [31:0]    offset;
    logic [31:0]    page_sum;
    logic [47:0]    span;
    res = '{status: fspm_pkg::STATUS_MISS, page_address: '0, page_bytes: '0,
            page_number: '0};
    case (rq.kind)
      fspm_pkg::REQ_CLEAR: begin
        sectors_loaded = 0;
        region_bytes   = '0;
        res.status     = fspm_pkg::STATUS_OK;
      end
      fspm_pkg::REQ_APPEND: begin
        if (sectors_loaded >= TABLE_DEPTH || rq.sector_pages == '0 ||
            rq.sector_page_bytes == '0) begin
          res.status = fspm_pkg::STATUS_REFUSED;
        end else begin
          layout_tbl[sectors_loaded] = '{start: model_base + region_bytes,
                                         page_bytes: rq.sector_page_bytes,
                                         page_total: rq.sector_pages};
          region_bytes   = region_bytes +
                           {16'b0, rq.sector_pages} * rq.sector_page_bytes;
          sectors_loaded = sectors_loaded + 1;
          res.status     = fspm_pkg::STATUS_OK;
        end
      end
      fspm_pkg::REQ_P2A: begin
        walk_idx = rq.page;
        for (int i = 0; i < sectors_loaded; i++) begin
          if (walk_idx < {16'b0, layout_tbl[i].page_total}) begin
            res.page_address = layout_tbl[i].start + walk_idx * layout_tbl[i].page_bytes;
            res.page_bytes   = layout_tbl[i].page_bytes;
            res.status       = fspm_pkg::STATUS_OK;
            break;
          end
          walk_idx = walk_idx - {16'b0, layout_tbl[i].page_total};
        end
      end
      fspm_pkg::REQ_A2P: begin
        page_base = '0;
        for (int i = 0; i < sectors_loaded; i++) begin
          span   = {32'b0, layout_tbl[i].page_total} * {16'b0, layout_tbl[i].page_bytes};
          offset = rq.address - layout_tbl[i].start;
          if (rq.address >= layout_tbl[i].start && {16'b0, offset} < span) begin
            page_sum        = page_base + offset / layout_tbl[i].page_bytes;
            res.page_number = page_sum[19:0];
            res.status      = fspm_pkg::STATUS_OK;
            break;
          end
          page_base = page_base + {16'b0, layout_tbl[i].page_total};
        end
      end
      fspm_pkg::REQ_RANGE: begin
        if (rq.length == '0) begin
          res.status = fspm_pkg::STATUS_OK;
        end else if (rq.address >= model_base) begin
          offset = rq.address - model_base;
          if (offset <= region_bytes && rq.length <= region_bytes - offset) begin
            res.status = fspm_pkg::STATUS_OK;
          end
        end
      end
      fspm_pkg::REQ_COUNT: begin
        page_sum        = loaded_page_total();
        res.page_number = page_sum[19:0];
        res.status      = fspm_pkg::STATUS_OK;
      end
      default: begin
        // reserved codes: no state change, miss status
      end
    endcase
    return res;
  endfunction

  // result checker: done_o is a one-cycle pulse taken at its closing edge
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", {30'b0, status_o}, '0);
      end else begin
        result_want = pending_results.pop_front();
        if (status_o !== result_want.status)
          report_mismatch("status", {30'b0, status_o}, {30'b0, result_want.status});
        if (page_address_o !== result_want.page_address)
          report_mismatch("page_address", page_address_o, result_want.page_address);
        if (page_bytes_o !== result_want.page_bytes)
          report_mismatch("page_bytes", page_bytes_o, result_want.page_bytes);
        if (page_number_o !== result_want.page_number)
          report_mismatch("page_number", {12'b0, page_number_o},
                          {12'b0, result_want.page_number});
      end
    end
  end

  function automatic map_request_t make_request(input logic [2:0] kind,
                                                input logic [31:0] address,
                                                input logic [31:0] length,
                                                input logic [31:0] page,
                                                input logic [15:0] pages,
                                                input logic [31:0] page_bytes);
    map_request_t rq;
    rq.kind              = kind;
    rq.address           = address;
    rq.length            = length;
    rq.page              = page;
    rq.sector_pages      = pages;
    rq.sector_page_bytes = page_bytes;
    return rq;
  endfunction

  function automatic map_request_t noise_request();
    return make_request(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                        16'($urandom), $urandom);
  endfunction

  function automatic map_request_t append_request();
    map_request_t rq;
    rq      = noise_request();
    rq.kind = fspm_pkg::REQ_APPEND;
    case ($urandom_range(0, 19))
      0: rq.sector_pages = '0;
      1: rq.sector_page_bytes = '0;
      2: rq.sector_pages = 16'hFFFF;
      3: rq.sector_page_bytes = '1;
      4: begin
        // fully random count and size
      end
      default: begin
        rq.sector_pages = 16'($urandom_range(1, 64));
        if ($urandom_range(0, 3) == 0) begin
          rq.sector_page_bytes = $urandom_range(1, 5000);
        end else begin
          rq.sector_page_bytes = 32'd1 << $urandom_range(0, 14);
        end
      end
    endcase
    return rq;
  endfunction

  function automatic logic [31:0] pick_page();
    logic [31:0] total;
    total = loaded_page_total();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return total;
      2:       return total - 1;
      default: return $urandom_range(0, total);
    endcase
  endfunction

  // mostly addresses inside a loaded sector, some at its edges
  function automatic logic [31:0] pick_address();
    fspm_pkg::entry_t e;
    logic [31:0]      span32;
    if (sectors_loaded == 0 || $urandom_range(0, 7) == 0) return $urandom;
    e      = layout_tbl[$urandom_range(0, sectors_loaded - 1)];
    span32 = {16'b0, e.page_total} * e.page_bytes;
    case ($urandom_range(0, 5))
      0:       return e.start - 1;
      1:       return e.start + span32;
      2:       return e.start + span32 - 1;
      default: return e.start +
                      $urandom_range(0, {16'b0, e.page_total} - 32'd1) * e.page_bytes +
                      $urandom % e.page_bytes;
    endcase
  endfunction

  function automatic map_request_t lookup_request();
    map_request_t rq;
    logic [31:0]  offset;
    rq = noise_request();
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        rq.kind = fspm_pkg::REQ_P2A;
        rq.page = pick_page();
      end
      3, 4, 5: begin
        rq.kind    = fspm_pkg::REQ_A2P;
        rq.address = pick_address();
      end
      6, 7: begin
        rq.kind = fspm_pkg::REQ_RANGE;
        offset  = $urandom_range(0, region_bytes);
        case ($urandom_range(0, 5))
          0:       rq.address = model_base - 1;
          1:       rq.address = $urandom;
          default: rq.address = model_base + offset;
        endcase
        case ($urandom_range(0, 5))
          0:       rq.length = '0;
          1:       rq.length = region_bytes - offset;
          2:       rq.length = region_bytes - offset + 1;
          3:       rq.length = $urandom;
          default: rq.length = $urandom_range(1, 4096);
        endcase
      end
      8: rq.kind = fspm_pkg::REQ_COUNT;
      default: begin
        // random request, fields as drawn
      end
    endcase
    return rq;
  endfunction

  // one request transfer, then an optional idle gap
  task automatic send_request(input map_request_t rq);
    start_i                 <= 1'b1;
    req_type_i              <= rq.kind;
    query_address_i         <= rq.address;
    range_length_i          <= rq.length;
    query_page_i            <= rq.page;
    new_sector_pages_i      <= rq.sector_pages;
    new_sector_page_bytes_i <= rq.sector_page_bytes;
    forever begin
      @(posedge clk_i);
      if (busy_o === 1'b0) break;
    end
    pending_results.push_back(predict_mapper(rq));
    if (rq.kind != REQ_RSVD6 && rq.kind != REQ_RSVD7) accepted_items++;
    if ($urandom_range(1, 100) <= gap_percent) begin
      start_i <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(20, 90)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_until_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of region_base followed by a read back
  task automatic write_region_base(input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_REGION_BASE;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    model_base = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) report_mismatch("region_base readback", readback, value);
  endtask

  // empty table, refusals, a full table and each lookup kind
  task automatic test_directed_layout();
    wait_until_drained();
    write_region_base(32'h0800_0000);
    gap_percent = 0;
    send_request(make_request(fspm_pkg::REQ_CLEAR, '0, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_P2A, '0, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'd0, 32'h800));
    send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'd4, 32'h0));
    for (int j = 0; j < TABLE_DEPTH - 2; j++) begin
      send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'(j + 1),
                                32'h400 << (j % 4)));
    end
    // sectors: 1 x 0x400, 2 x 0x800, 3 x 0x1000, ...; 105 pages in all
    send_request(make_request(fspm_pkg::REQ_P2A, '0, '0, 32'd2, '0, '0));
    send_request(make_request(fspm_pkg::REQ_P2A, '0, '0, 32'd104, '0, '0));
    send_request(make_request(fspm_pkg::REQ_P2A, '0, '0, 32'd105, '0, '0));
    send_request(make_request(fspm_pkg::REQ_A2P, model_base, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_A2P, model_base + 32'h2405, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_A2P, model_base - 1, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_RANGE, 32'hFFFF_FFFF, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_RANGE, model_base, region_bytes, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_RANGE, model_base + 1, region_bytes,
                              '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_RANGE, model_base - 1, 32'd1, '0, '0, '0));
    // largest sectors, then the table is full
    send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'hFFFF, 32'h1000));
    send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'hFFFF, 32'hFFFF_FFFF));
    send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'd1, 32'd1));
    send_request(make_request(fspm_pkg::REQ_COUNT, '0, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_A2P, 32'hFFFF_FFFF, '0, '0, '0, '0));
    send_request(make_request(REQ_RSVD6, '0, '0, '0, '0, '0));
    send_request(make_request(REQ_RSVD7, '1, '1, '1, '1, '1));
  endtask

  // new base applies to range checks only; loaded sectors stay put
  task automatic test_base_moves();
    wait_until_drained();
    send_request(make_request(fspm_pkg::REQ_CLEAR, '0, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_APPEND, '0, '0, '0, 16'd8, 32'h200));
    wait_until_drained();
    write_region_base(32'h0900_0000);
    send_request(make_request(fspm_pkg::REQ_RANGE, 32'h0800_0000, 32'd4, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_A2P, 32'h0800_0010, '0, '0, '0, '0));
    send_request(make_request(fspm_pkg::REQ_P2A, '0, '0, 32'd0, '0, '0));
  endtask

  task automatic run_layout_session();
    int unsigned n_sectors;
    send_request(make_request(fspm_pkg::REQ_CLEAR, $urandom, $urandom, $urandom,
                              16'($urandom), $urandom));
    if ($urandom_range(0, 3) == 0) begin
      n_sectors = $urandom_range(15, 18);
    end else begin
      n_sectors = $urandom_range(1, 8);
    end
    repeat (n_sectors) begin
      send_request(append_request());
      if ($urandom_range(0, 4) == 0) send_request(lookup_request());
    end
    repeat ($urandom_range(8, 30)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(noise_request());
      end else begin
        send_request(lookup_request());
      end
    end
    if ($urandom_range(0, 7) == 0) wait_until_drained();
  endtask

  // random layouts at one region base and one sender idle rate
  task automatic test_random_layouts(input logic [31:0] base, input int idle_pct,
                                     input int item_count);
    int phase_start;
    wait_until_drained();
    write_region_base(base);
    gap_percent = idle_pct;
    phase_start = accepted_items;
    // old table seen from the new base
    repeat (10) send_request(lookup_request());
    while (accepted_items - phase_start < item_count) run_layout_session();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_layout();
    test_base_moves();
    test_random_layouts(32'h0000_0000, 0, 120);
    test_random_layouts(32'hFFFF_F000, 70, 120);
    test_random_layouts($urandom, 31, 120);
    test_random_layouts(32'hFFFF_FFFF, 0, 120);
    test_random_layouts(32'h2000_0000, 70, 120);
    wait_until_drained();
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> flash_sector_page_mapper_top.f
design/fspm_pkg.sv
design/fspm_table.sv
design/fspm_divider.sv
design/flash_sector_page_mapper_top.sv
tb/flash_sector_page_mapper_top_tb.sv
